// ===== design/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Countdown timer package
// Codes, register offsets and result type shared by the timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

  // Item kinds carried on the input tuser
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_OTHER = 3'd3;
  localparam logic [2:0] MODE_RESET = 3'd4;

  typedef enum logic [2:0] {
    RESP_OK      = 3'd0,
    RESP_GENERIC = 3'd1,
    RESP_ADDR    = 3'd2,
    RESP_BURST   = 3'd3,
    RESP_BYTE_EN = 3'd4,
    RESP_CMD     = 3'd5
  } resp_e;

  // Register byte offsets
  localparam logic [4:0] OFS_CTRL   = 5'd0;
  localparam logic [4:0] OFS_LOAD   = 5'd4;
  localparam logic [4:0] OFS_VALUE  = 5'd8;
  localparam logic [4:0] OFS_STATUS = 5'd12;
  localparam logic [4:0] OFS_ID     = 5'd16;

  // CTRL bit positions
  localparam int unsigned CTL_EN  = 0;
  localparam int unsigned CTL_PER = 1;
  localparam int unsigned CTL_IE  = 2;

  // Configuration port register indexes
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_ID     = 1'b1;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned OUT_W  = 40;

  typedef struct packed {
    resp_e       resp;
    logic [31:0] rdata;
    logic        irq;
  } cdt_result_t;

endpackage

`default_nettype wire

// ===== design/countdown_timer_registers_top.sv =====
// ----------------------------------------------------------------------------
// Countdown timer registers, top level
// Input register, timer core, result register and configuration port.
// ----------------------------------------------------------------------------
//  channel   | direction | fields
//  s_axis    | in        | tuser: mode; tdata: address, write_data, byte_lanes,
//            |           |   length_error, burst_error, lanes_empty
//  m_axis    | out       | tdata: response, read_data, irq
//  apb       | in        | 0x0 period_ticks, 0x4 id_value
//
//  One transfer per cycle sustained while m_axis is not stalled; each input is
//  held in the input register, then its result in the result register.
//  The timer state update for one item is a single step in the core, which
//  bounds the rate at one item per cycle.
//  Reset is asynchronous; the block accepts transfers right after reset.
//  A stall on m_axis holds the result register and then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_registers_top
  import cdt_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 12,
  localparam int unsigned IN_W = ((ADDR_BITS + 39 + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // address, write_data, byte_lanes, length_error, burst_error, lanes_empty
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  // mode
  input  wire logic [2:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // response, read_data, irq
  output logic [OUT_W-1:0]       m_axis_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic                 in_valid_q, in_valid_d;
  logic [2:0]           mode_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [31:0]          wdata_q;
  logic [3:0]           lanes_q;
  logic                 length_err_q, burst_err_q, lanes_empty_q;

  logic        out_valid_q, out_valid_d;
  cdt_result_t result_q, result_d;

  logic [15:0] period_q;
  logic [31:0] id_value_q;

  logic advance, step, in_fire, cfg_wr;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_fire || (in_valid_q && !step);
  assign out_valid_d   = step || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q        <= s_axis_tuser;
      addr_q        <= s_axis_tdata[ADDR_BITS-1:0];
      wdata_q       <= s_axis_tdata[ADDR_BITS+31:ADDR_BITS];
      lanes_q       <= s_axis_tdata[ADDR_BITS+35:ADDR_BITS+32];
      length_err_q  <= s_axis_tdata[ADDR_BITS+36];
      burst_err_q   <= s_axis_tdata[ADDR_BITS+37];
      lanes_empty_q <= s_axis_tdata[ADDR_BITS+38];
    end
    if (step) begin
      result_q <= result_d;
    end
  end

  cdt_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .mode_i       (mode_q),
    .addr_i       (addr_q),
    .wdata_i      (wdata_q),
    .lanes_i      (lanes_q),
    .length_err_i (length_err_q),
    .burst_err_i  (burst_err_q),
    .lanes_empty_i(lanes_empty_q),
    .period_i     (period_q),
    .id_value_i   (id_value_q),
    .result_o     (result_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, result_q.irq, result_q.rdata, result_q.resp};

  // Configuration port: word-addressed, low address bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= 16'd1;
      id_value_q <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_PERIOD: period_q   <= pwdata[15:0];
        CFG_ID:     id_value_q <= pwdata;
        default:    period_q   <= period_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_PERIOD: prdata = {16'd0, period_q};
      CFG_ID:     prdata = id_value_q;
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cdt_core.sv =====
// ----------------------------------------------------------------------------
// Countdown timer core
// Timer state registers and the single-step update for one transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_core
  import cdt_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [2:0]           mode_i,
  input  wire logic [ADDR_BITS-1:0] addr_i,
  input  wire logic [31:0]          wdata_i,
  input  wire logic [3:0]           lanes_i,
  input  wire logic                 length_err_i,
  input  wire logic                 burst_err_i,
  input  wire logic                 lanes_empty_i,
  input  wire logic [15:0]          period_i,
  input  wire logic [31:0]          id_value_i,
  output cdt_result_t               result_o
);

  logic [2:0]  ctrl_q, ctrl_d;
  logic [31:0] reload_q, reload_d;
  logic [31:0] count_q, count_d;
  logic        pending_q, pending_d;
  logic [15:0] phase_q, phase_d;

  logic [31:0] lane_mask;
  logic [15:0] per_eff;
  logic        hit_ctrl, hit_load, hit_value, hit_status, hit_id;
  resp_e       resp;
  logic [31:0] rdata;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      lane_mask[b*8 +: 8] = {8{lanes_i[b]}};
    end
  end

  assign per_eff    = (period_i == 16'd0) ? 16'd1 : period_i;
  assign hit_ctrl   = (addr_i == ADDR_BITS'(OFS_CTRL));
  assign hit_load   = (addr_i == ADDR_BITS'(OFS_LOAD));
  assign hit_value  = (addr_i == ADDR_BITS'(OFS_VALUE));
  assign hit_status = (addr_i == ADDR_BITS'(OFS_STATUS));
  assign hit_id     = (addr_i == ADDR_BITS'(OFS_ID));

  always_comb begin
    ctrl_d    = ctrl_q;
    reload_d  = reload_q;
    count_d   = count_q;
    pending_d = pending_q;
    phase_d   = phase_q;
    resp      = RESP_OK;
    rdata     = 32'd0;
    case (mode_i)
      MODE_TICK: begin
        if (ctrl_q[CTL_EN]) begin
          if (({1'b0, phase_q} + 17'd1) < {1'b0, per_eff}) begin
            phase_d = phase_q + 16'd1;
          end else begin
            phase_d = 16'd0;
            if (count_q != 32'd0) begin
              count_d = count_q - 32'd1;
            end
            if (count_q <= 32'd1) begin
              pending_d = 1'b1;
              if (ctrl_q[CTL_PER] && (reload_q != 32'd0)) begin
                count_d = reload_q;
              end else begin
                ctrl_d[CTL_EN] = 1'b0;
              end
            end
          end
        end
      end
      MODE_RESET: begin
        ctrl_d    = 3'd0;
        reload_d  = 32'd0;
        count_d   = 32'd0;
        pending_d = 1'b0;
        phase_d   = 16'd0;
      end
      default: begin
        if (length_err_i) begin
          resp = RESP_GENERIC;
        end else if (addr_i[1:0] != 2'b00) begin
          resp = RESP_ADDR;
        end else if (burst_err_i) begin
          resp = RESP_BURST;
        end else if (lanes_empty_i) begin
          resp = RESP_BYTE_EN;
        end else if (mode_i == MODE_READ) begin
          if (hit_ctrl) begin
            rdata = {29'd0, ctrl_q} & lane_mask;
          end else if (hit_load) begin
            rdata = reload_q & lane_mask;
          end else if (hit_value) begin
            rdata = count_q & lane_mask;
          end else if (hit_status) begin
            rdata = {31'd0, pending_q} & lane_mask;
          end else if (hit_id) begin
            rdata = id_value_i & lane_mask;
          end else begin
            resp = RESP_ADDR;
          end
        end else if (mode_i != MODE_WRITE) begin
          resp = RESP_CMD;
        end else if (hit_ctrl) begin
          ctrl_d = (ctrl_q & ~lane_mask[2:0]) | (wdata_i[2:0] & lane_mask[2:0]);
        end else if (hit_load) begin
          reload_d = (reload_q & ~lane_mask) | (wdata_i & lane_mask);
          count_d  = reload_d;
        end else if (hit_status) begin
          if (wdata_i[0] && lanes_i[0]) begin
            pending_d = 1'b0;
          end
        end else if (hit_value || hit_id) begin
          resp = RESP_CMD;
        end else begin
          resp = RESP_ADDR;
        end
      end
    endcase
    if (!ctrl_d[CTL_EN]) begin
      phase_d = 16'd0;
    end
  end

  assign result_o.resp  = resp;
  assign result_o.rdata = rdata;
  assign result_o.irq   = pending_d & ctrl_d[CTL_IE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= 3'd0;
      reload_q  <= 32'd0;
      count_q   <= 32'd0;
      pending_q <= 1'b0;
      phase_q   <= 16'd0;
    end else if (step_i) begin
      ctrl_q    <= ctrl_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      phase_q   <= phase_d;
    end
  end

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_q[CTL_EN] |-> (phase_q == 16'd0))
    else $error("tick phase not held while timer disabled");

  a_reg_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_i == MODE_RESET)) |=>
      ((ctrl_q == 3'd0) && (count_q == 32'd0) && (reload_q == 32'd0) && !pending_q))
    else $error("register reset left state behind");

  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (resp != RESP_OK)) |=>
      ($stable(ctrl_q) && $stable(reload_q) && $stable(count_q) && $stable(pending_q)))
    else $error("failed access changed timer state");

  a_tick_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_i == MODE_TICK) && !ctrl_q[CTL_EN]) |=>
      ($stable(count_q) && $stable(pending_q)))
    else $error("tick advanced a disabled timer");

endmodule

`default_nettype wire
